// File: hw/rtl/hee_pkg.sv
// ----------------------------------------------------------------------------
// hee_pkg: shared types, constants and lookups for the HTML entity escaper
// Holds the escape strings and the per-byte length and character lookups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hee_pkg;

    localparam int BYTE_W = 8;
    localparam int MAX_SEQ = 8;
    localparam int IDX_W = $clog2(MAX_SEQ);
    localparam int LEN_W = $clog2(MAX_SEQ + 1);

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [MAX_SEQ*BYTE_W-1:0] seq_t;

    // special input characters
    localparam byte_t CHAR_CR = 8'h0D;
    localparam byte_t CHAR_LF = 8'h0A;
    localparam byte_t CHAR_TAB = 8'h09;
    localparam byte_t CHAR_SPACE = 8'h20;
    localparam byte_t CHAR_EXCL = 8'h21;
    localparam byte_t CHAR_QUOT = 8'h22;
    localparam byte_t CHAR_NUM = 8'h23;
    localparam byte_t CHAR_AMP = 8'h26;
    localparam byte_t CHAR_APOS = 8'h27;
    localparam byte_t CHAR_DASH = 8'h2D;
    localparam byte_t CHAR_SEMI = 8'h3B;
    localparam byte_t CHAR_LT = 8'h3C;
    localparam byte_t CHAR_EQUALS = 8'h3D;
    localparam byte_t CHAR_GT = 8'h3E;
    localparam byte_t CHAR_TILDE = 8'h7E;

    // escape strings, right-justified (last character in the low byte)
    localparam seq_t SEQ_BR = seq_t'("<br>");
    localparam seq_t SEQ_AMP = seq_t'("&amp;");
    localparam seq_t SEQ_SEMI = seq_t'("&semi;");
    localparam seq_t SEQ_LT = seq_t'("&lt;");
    localparam seq_t SEQ_GT = seq_t'("&gt;");
    localparam seq_t SEQ_TAB = seq_t'("&tab;");
    localparam seq_t SEQ_EXCL = seq_t'("&excl;");
    localparam seq_t SEQ_QUOT = seq_t'("&quot;");
    localparam seq_t SEQ_NUM = seq_t'("&num;");
    localparam seq_t SEQ_APOS = seq_t'("&apos;");
    localparam seq_t SEQ_EQUALS = seq_t'("&equals;");
    localparam seq_t SEQ_DASH = seq_t'("&dash;");
    localparam seq_t SEQ_TILDE = seq_t'("&tilde;");
    localparam seq_t SEQ_NBSP = seq_t'("&nbsp;");

    // number of output bytes for one input byte (plain bytes give one)
    function automatic len_t esc_len(input byte_t b);
        len_t n;
        case (b)
            CHAR_LF, CHAR_LT, CHAR_GT: n = len_t'(4);
            CHAR_AMP, CHAR_TAB, CHAR_NUM: n = len_t'(5);
            CHAR_SEMI, CHAR_EXCL, CHAR_QUOT, CHAR_APOS, CHAR_DASH, CHAR_SPACE:
                n = len_t'(6);
            CHAR_TILDE: n = len_t'(7);
            CHAR_EQUALS: n = len_t'(8);
            default: n = len_t'(1);
        endcase
        return n;
    endfunction

    // escape string for one input byte (plain bytes map to themselves)
    function automatic seq_t esc_seq(input byte_t b);
        seq_t s;
        case (b)
            CHAR_LF: s = SEQ_BR;
            CHAR_AMP: s = SEQ_AMP;
            CHAR_SEMI: s = SEQ_SEMI;
            CHAR_LT: s = SEQ_LT;
            CHAR_GT: s = SEQ_GT;
            CHAR_TAB: s = SEQ_TAB;
            CHAR_EXCL: s = SEQ_EXCL;
            CHAR_QUOT: s = SEQ_QUOT;
            CHAR_NUM: s = SEQ_NUM;
            CHAR_APOS: s = SEQ_APOS;
            CHAR_EQUALS: s = SEQ_EQUALS;
            CHAR_DASH: s = SEQ_DASH;
            CHAR_TILDE: s = SEQ_TILDE;
            CHAR_SPACE: s = SEQ_NBSP;
            default: s = seq_t'(b);
        endcase
        return s;
    endfunction

    // character k of the output run for input byte b
    function automatic byte_t esc_char(input byte_t b, input idx_t k);
        seq_t s;
        len_t n;
        idx_t sel;
        s = esc_seq(b);
        n = esc_len(b);
        sel = idx_t'(n - len_t'(1) - len_t'(k));
        return s[sel*BYTE_W +: BYTE_W];
    endfunction

endpackage

// File: hw/rtl/html_entity_escaper_unit.sv
// ----------------------------------------------------------------------------
// html_entity_escaper_unit: byte stream to HTML-safe text
// Registers one input byte, walks its escape string and emits one byte per beat.
// ----------------------------------------------------------------------------
// Each input beat yields one output beat for a plain byte, four to eight for
// a byte that becomes a named entity or <br>, and none for a carriage return.
// Output runs one byte per cycle while m_ready is high; a plain byte lets the
// input keep streaming, while an entity holds the input register, and so the
// input, until its last byte is loaded. m_run_last marks the final byte of
// each run. The output register lets the next input be taken while a result
// still waits. No configuration and no state beyond the current byte.
`timescale 1ns / 1ps

module html_entity_escaper_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  hee_pkg::byte_t       s_text_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output hee_pkg::byte_t       m_out_byte,
    output logic                 m_run_last
);
    import hee_pkg::*;

    logic  hold_valid_reg, hold_valid_next;
    byte_t hold_byte_reg;
    idx_t  idx_reg, idx_next;
    logic  m_valid_reg, m_valid_next;
    byte_t m_out_byte_reg;
    logic  m_run_last_reg;

    logic  out_load;
    logic  is_last;
    logic  hold_done;
    logic  s_take;

    // run position and handshake decisions
    assign out_load  = !m_valid_reg || m_ready;
    assign is_last   = (len_t'(idx_reg) + len_t'(1)) == esc_len(hold_byte_reg);
    assign hold_done = hold_valid_reg && out_load && is_last;
    assign s_ready   = !hold_valid_reg || hold_done;
    assign s_take    = s_valid && s_ready;

    // input holding register control
    always_comb begin
        hold_valid_next = hold_valid_reg;
        idx_next = idx_reg;
        if (hold_valid_reg && out_load) begin
            idx_next = idx_reg + idx_t'(1);
        end
        if (hold_done) begin
            hold_valid_next = 1'b0;
        end
        if (s_take) begin
            // carriage return is dropped at the door
            hold_valid_next = (s_text_byte != CHAR_CR);
            idx_next = '0;
        end
    end

    // output register control
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = hold_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            idx_reg <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_take) begin
            hold_byte_reg <= s_text_byte;
        end
        if (out_load && hold_valid_reg) begin
            m_out_byte_reg <= esc_char(hold_byte_reg, idx_reg);
            m_run_last_reg <= is_last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_run_last = m_run_last_reg;

endmodule

// File: hw/rtl/hee_checker.sv
// ----------------------------------------------------------------------------
// hee_checker: port-level assertions for the HTML entity escaper
// Watches the top level's ports and is bound to every instance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hee_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input hee_pkg::byte_t s_text_byte,
    input logic           m_valid,
    input logic           m_ready,
    input hee_pkg::byte_t m_out_byte,
    input logic           m_run_last
);
    import hee_pkg::*;

    // a stalled input beat keeps its payload
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_text_byte))
        else $error("input beat changed while stalled");

    // a stalled output beat keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_run_last))
        else $error("output beat changed while stalled");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // carriage returns never reach the output
    a_no_cr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_out_byte != CHAR_CR)
        else $error("carriage return emitted");

    // a run continues without a gap once started
    a_run_gapless: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_run_last |=> m_valid)
        else $error("gap inside an escape run");

endmodule

bind html_entity_escaper_unit hee_checker u_hee_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_text_byte (s_text_byte),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_byte  (m_out_byte),
    .m_run_last  (m_run_last)
);
